FILE: hdl/clpv_pkg.sv
package clpv_pkg;

   localparam logic [7:0] CH_CR   = 8'h0D;
   localparam logic [7:0] CH_LF   = 8'h0A;
   localparam logic [7:0] CH_BAR  = 8'h7C;
   localparam logic [7:0] CH_ZERO = 8'h30;
   localparam logic [7:0] CH_NINE = 8'h39;
   localparam logic [7:0] CH_DASH = 8'h2D;
   localparam logic [7:0] CH_T    = 8'h54;
   localparam logic [7:0] CH_COLON = 8'h3A;
   localparam logic [7:0] CH_Z    = 8'h5A;

   localparam int STAMP_LEN = 20;

   localparam logic [3:0] ERR_OK          = 4'd0;
   localparam logic [3:0] ERR_FORMAT      = 4'd1;
   localparam logic [3:0] ERR_PREFIX      = 4'd2;
   localparam logic [3:0] ERR_ID          = 4'd3;
   localparam logic [3:0] ERR_CMD_ID      = 4'd4;
   localparam logic [3:0] ERR_STATE       = 4'd5;
   localparam logic [3:0] ERR_POWER       = 4'd6;
   localparam logic [3:0] ERR_STATE_POWER = 4'd7;
   localparam logic [3:0] ERR_STAMP       = 4'd8;

   localparam logic [1:0] DISP_STANDBY = 2'd0;
   localparam logic [1:0] DISP_LIMITED = 2'd1;
   localparam logic [1:0] DISP_FULL    = 2'd2;

   // state word candidates
   localparam int CAND_STANDBY   = 0;
   localparam int CAND_AVAILABLE = 1;

   // register indexes
   localparam logic [2:0] REG_ID_LEN    = 3'd0;
   localparam logic [2:0] REG_ID_FIRST  = 3'd1;
   localparam logic [2:0] REG_ID_SECOND = 3'd2;
   localparam logic [2:0] REG_LIMITED   = 3'd3;
   localparam logic [2:0] REG_FULL      = 3'd4;

   // one finished line, as classified by the front end
   typedef struct packed {
      logic [3:0]                     early_err;
      logic                           stamp_len_ok;
      logic [1:0]                     state_match;
      logic [31:0]                    cmd;
      logic [31:0]                    pwr;
      logic [STAMP_LEN-1:0][7:0]      stamp;
   } summ_type;

   typedef struct packed {
      logic [3:0]  error_code;
      logic [31:0] command_id;
      logic        target_available;
      logic [31:0] power_limit_w;
      logic [1:0]  display_mode;
      logic [13:0] stamp_year;
      logic [3:0]  stamp_month;
      logic [4:0]  stamp_day;
      logic [4:0]  stamp_hour;
      logic [5:0]  stamp_minute;
      logic [5:0]  stamp_second;
   } rslt_type;

   function automatic logic is_digit(logic [7:0] c);
      return (c >= CH_ZERO) && (c <= CH_NINE);
   endfunction

   // {bad, acc}: decimal accumulate with overflow rejection
   function automatic logic [32:0] add_digit(logic [31:0] acc, logic [7:0] c);
      logic [35:0] v;
      logic [7:0]  d;
      d = c - CH_ZERO;
      v = ({4'b0, acc} << 3) + ({4'b0, acc} << 1) + {28'b0, d};
      if (!is_digit(c)) begin
         return {1'b1, acc};
      end
      if (v[35:32] != 4'b0) begin
         return {1'b1, 32'b0};
      end
      return {1'b0, v[31:0]};
   endfunction

   function automatic logic [7:0] prefix_char(logic [1:0] i);
      unique case (i)
         2'd0: return 8'h43;
         2'd1: return 8'h4D;
         2'd2: return 8'h44;
         default: return 8'h00;
      endcase
   endfunction

   function automatic logic [7:0] standby_char(logic [2:0] i);
      unique case (i)
         3'd0: return 8'h53;
         3'd1: return 8'h54;
         3'd2: return 8'h41;
         3'd3: return 8'h4E;
         3'd4: return 8'h44;
         3'd5: return 8'h42;
         3'd6: return 8'h59;
         default: return 8'h00;
      endcase
   endfunction

   function automatic logic [7:0] avail_char(logic [3:0] i);
      unique case (i)
         4'd0: return 8'h41;
         4'd1: return 8'h56;
         4'd2: return 8'h41;
         4'd3: return 8'h49;
         4'd4: return 8'h4C;
         4'd5: return 8'h41;
         4'd6: return 8'h42;
         4'd7: return 8'h4C;
         4'd8: return 8'h45;
         default: return 8'h00;
      endcase
   endfunction

   // two ASCII digits to a value 0..99
   function automatic logic [6:0] two_dig(logic [7:0] hi, logic [7:0] lo);
      logic [6:0] h;
      logic [6:0] l;
      h = 7'(hi[3:0]);
      l = 7'(lo[3:0]);
      return (h << 3) + (h << 1) + l;
   endfunction

endpackage

FILE: hdl/clpv_front.sv
module clpv_front import clpv_pkg::*; #(
   parameter int LINE_LIMIT   = 128,
   parameter int ID_MAX_CHARS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_rx_byte,
   input  logic [4:0]  cfg_id_len,
   input  logic [127:0] cfg_id,
   input  logic        q_full,
   output logic        q_push,
   output summ_type    q_data
);

   logic [2:0]  field_ff, field_in;
   logic        extra_ff, extra_in;
   logic [7:0]  line_cnt_ff, line_cnt_in;
   logic [7:0]  fcnt_ff, fcnt_in;
   logic        prefix_ok_ff, prefix_ok_in;
   logic        id_match_ff, id_match_in;
   logic        id_len_ok_ff, id_len_ok_in;
   logic [31:0] cmd_acc_ff, cmd_acc_in;
   logic        cmd_bad_ff, cmd_bad_in;
   logic [1:0]  sm_ff, sm_in;
   logic [31:0] pwr_acc_ff, pwr_acc_in;
   logic        pwr_bad_ff, pwr_bad_in;
   logic [STAMP_LEN-1:0][7:0] stamp_ff, stamp_in;

   logic        accept;
   logic        is_end;
   logic [32:0] dig;
   logic [7:0]  c;

   assign c         = req_rx_byte;
   assign req_ready = !q_full;
   assign accept    = req_valid && req_ready;
   assign is_end    = (c == CH_CR) || (c == CH_LF);
   assign q_push    = accept && is_end;

   // line classification up to the checks that need the timestamp
   always_comb begin
      q_data.stamp_len_ok = (fcnt_ff == 8'(STAMP_LEN));
      q_data.state_match  = sm_ff;
      q_data.cmd          = cmd_acc_ff;
      q_data.pwr          = pwr_acc_ff;
      q_data.stamp        = stamp_ff;
      priority if ((line_cnt_ff == 8'd0) || (line_cnt_ff >= 8'(LINE_LIMIT)) ||
                   (field_ff != 3'd5) || extra_ff) begin
         q_data.early_err = ERR_FORMAT;
      end else if (!prefix_ok_ff) begin
         q_data.early_err = ERR_PREFIX;
      end else if (!id_len_ok_ff) begin
         q_data.early_err = ERR_ID;
      end else if (cmd_bad_ff || (cmd_acc_ff == 32'd0)) begin
         q_data.early_err = ERR_CMD_ID;
      end else if (sm_ff == 2'b00) begin
         q_data.early_err = ERR_STATE;
      end else if (pwr_bad_ff) begin
         q_data.early_err = ERR_POWER;
      end else if ((fcnt_ff == 8'd0) || (fcnt_ff > 8'(STAMP_LEN))) begin
         q_data.early_err = ERR_STAMP;
      end else if (!id_match_ff) begin
         q_data.early_err = ERR_ID;
      end else begin
         q_data.early_err = ERR_OK;
      end
   end

   always_comb begin
      field_in     = field_ff;
      extra_in     = extra_ff;
      line_cnt_in  = line_cnt_ff;
      fcnt_in      = fcnt_ff;
      prefix_ok_in = prefix_ok_ff;
      id_match_in  = id_match_ff;
      id_len_ok_in = id_len_ok_ff;
      cmd_acc_in   = cmd_acc_ff;
      cmd_bad_in   = cmd_bad_ff;
      sm_in        = sm_ff;
      pwr_acc_in   = pwr_acc_ff;
      pwr_bad_in   = pwr_bad_ff;
      stamp_in     = stamp_ff;
      dig          = add_digit((field_ff == 3'd2) ? cmd_acc_ff : pwr_acc_ff, c);
      if (accept) begin
         if (is_end) begin
            field_in     = 3'd0;
            extra_in     = 1'b0;
            line_cnt_in  = 8'd0;
            fcnt_in      = 8'd0;
            prefix_ok_in = 1'b1;
            id_match_in  = 1'b1;
            id_len_ok_in = 1'b0;
            cmd_acc_in   = 32'd0;
            cmd_bad_in   = 1'b0;
            sm_in        = 2'b11;
            pwr_acc_in   = 32'd0;
            pwr_bad_in   = 1'b0;
         end else begin
            if (line_cnt_ff < 8'(LINE_LIMIT)) begin
               line_cnt_in = line_cnt_ff + 8'd1;
            end
            if (c == CH_BAR) begin
               if (field_ff < 3'd5) begin
                  unique case (field_ff)
                     3'd0: prefix_ok_in = prefix_ok_ff && (fcnt_ff == 8'd3);
                     3'd1: begin
                        id_len_ok_in = (fcnt_ff >= 8'd1) && (fcnt_ff <= 8'(ID_MAX_CHARS));
                        id_match_in  = id_match_ff && (fcnt_ff == {3'b0, cfg_id_len}) &&
                                       (cfg_id_len != 5'd0);
                     end
                     3'd2: cmd_bad_in = cmd_bad_ff || (fcnt_ff == 8'd0);
                     3'd3: begin
                        sm_in[CAND_STANDBY]   = sm_ff[CAND_STANDBY] && (fcnt_ff == 8'd7);
                        sm_in[CAND_AVAILABLE] = sm_ff[CAND_AVAILABLE] && (fcnt_ff == 8'd9);
                     end
                     3'd4: pwr_bad_in = pwr_bad_ff || (fcnt_ff == 8'd0);
                     default: ;
                  endcase
                  field_in = field_ff + 3'd1;
                  fcnt_in  = 8'd0;
               end else begin
                  extra_in = 1'b1;
               end
            end else if (!extra_ff) begin
               unique case (field_ff)
                  3'd0: prefix_ok_in = prefix_ok_ff && (fcnt_ff < 8'd3) &&
                                       (prefix_char(fcnt_ff[1:0]) == c);
                  3'd1: id_match_in = id_match_ff && (fcnt_ff < 8'(ID_MAX_CHARS)) &&
                                      (fcnt_ff < 8'd16) &&
                                      (cfg_id[{fcnt_ff[3:0], 3'b000} +: 8] == c);
                  3'd2: begin
                     cmd_acc_in = dig[31:0];
                     cmd_bad_in = cmd_bad_ff || dig[32];
                  end
                  3'd3: begin
                     sm_in[CAND_STANDBY]   = sm_ff[CAND_STANDBY] && (fcnt_ff < 8'd7) &&
                                             (standby_char(fcnt_ff[2:0]) == c);
                     sm_in[CAND_AVAILABLE] = sm_ff[CAND_AVAILABLE] && (fcnt_ff < 8'd9) &&
                                             (avail_char(fcnt_ff[3:0]) == c);
                  end
                  3'd4: begin
                     pwr_acc_in = dig[31:0];
                     pwr_bad_in = pwr_bad_ff || dig[32];
                  end
                  default: begin
                     if (fcnt_ff < 8'(STAMP_LEN)) begin
                        stamp_in[fcnt_ff[4:0]] = c;
                     end
                  end
               endcase
               if (fcnt_ff != 8'd255) begin
                  fcnt_in = fcnt_ff + 8'd1;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         field_ff     <= 3'd0;
         extra_ff     <= 1'b0;
         line_cnt_ff  <= 8'd0;
         fcnt_ff      <= 8'd0;
         prefix_ok_ff <= 1'b1;
         id_match_ff  <= 1'b1;
         id_len_ok_ff <= 1'b0;
         cmd_acc_ff   <= 32'd0;
         cmd_bad_ff   <= 1'b0;
         sm_ff        <= 2'b11;
         pwr_acc_ff   <= 32'd0;
         pwr_bad_ff   <= 1'b0;
      end else begin
         field_ff     <= field_in;
         extra_ff     <= extra_in;
         line_cnt_ff  <= line_cnt_in;
         fcnt_ff      <= fcnt_in;
         prefix_ok_ff <= prefix_ok_in;
         id_match_ff  <= id_match_in;
         id_len_ok_ff <= id_len_ok_in;
         cmd_acc_ff   <= cmd_acc_in;
         cmd_bad_ff   <= cmd_bad_in;
         sm_ff        <= sm_in;
         pwr_acc_ff   <= pwr_acc_in;
         pwr_bad_ff   <= pwr_bad_in;
      end
      stamp_ff <= stamp_in;
   end

endmodule

FILE: hdl/clpv_queue.sv
module clpv_queue import clpv_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  summ_type push_data,
   output logic     full,
   input  logic     pop,
   output logic     head_valid,
   output summ_type head_data
);

   summ_type   mem_ff [2];
   logic       wr_ptr_ff;
   logic       rd_ptr_ff;
   logic [1:0] count_ff;

   assign full       = (count_ff == 2'd2);
   assign head_valid = (count_ff != 2'd0);
   assign head_data  = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
         count_ff <= count_ff + {1'b0, push} - {1'b0, pop};
      end
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

FILE: hdl/clpv_back.sv
module clpv_back import clpv_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        head_valid,
   input  summ_type    head_data,
   output logic        pop,
   input  logic [31:0] cfg_limited,
   input  logic [31:0] cfg_full,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rslt_type    rslt
);

   logic      valid_ff;
   rslt_type  rslt_ff;
   rslt_type  rslt_in;
   logic      fmt_ok;
   logic      digits_ok;
   logic      range_ok;
   logic [3:0] err;
   logic [6:0] yr_hi, yr_lo, mo, dy, hr, mi, se;
   logic [STAMP_LEN-1:0][7:0] s;

   assign s         = head_data.stamp;
   assign pop       = head_valid && (!valid_ff || rsp_ready);
   assign rsp_valid = valid_ff;
   assign rslt      = rslt_ff;

   always_comb begin
      fmt_ok = (s[4] == CH_DASH) && (s[7] == CH_DASH) && (s[10] == CH_T) &&
               (s[13] == CH_COLON) && (s[16] == CH_COLON) && (s[19] == CH_Z);
      digits_ok = is_digit(s[0]) && is_digit(s[1]) && is_digit(s[2]) && is_digit(s[3]) &&
                  is_digit(s[5]) && is_digit(s[6]) && is_digit(s[8]) && is_digit(s[9]) &&
                  is_digit(s[11]) && is_digit(s[12]) && is_digit(s[14]) &&
                  is_digit(s[15]) && is_digit(s[17]) && is_digit(s[18]);
      yr_hi = two_dig(s[0], s[1]);
      yr_lo = two_dig(s[2], s[3]);
      mo    = two_dig(s[5], s[6]);
      dy    = two_dig(s[8], s[9]);
      hr    = two_dig(s[11], s[12]);
      mi    = two_dig(s[14], s[15]);
      se    = two_dig(s[17], s[18]);
      range_ok = (mo >= 7'd1) && (mo <= 7'd12) && (dy >= 7'd1) && (dy <= 7'd31) &&
                 (hr <= 7'd23) && (mi <= 7'd59) && (se <= 7'd59);

      priority if (head_data.early_err != ERR_OK) begin
         err = head_data.early_err;
      end else if (!head_data.stamp_len_ok || !fmt_ok || !digits_ok || !range_ok) begin
         err = ERR_STAMP;
      end else if (head_data.state_match[CAND_STANDBY]) begin
         err = (head_data.pwr == 32'd0) ? ERR_OK : ERR_STATE_POWER;
      end else if ((head_data.pwr != cfg_limited) && (head_data.pwr != cfg_full)) begin
         err = ERR_POWER;
      end else begin
         err = ERR_OK;
      end

      rslt_in = '0;
      rslt_in.error_code = err;
      if (err == ERR_OK) begin
         rslt_in.command_id       = head_data.cmd;
         rslt_in.target_available = head_data.state_match[CAND_AVAILABLE];
         rslt_in.power_limit_w    = head_data.pwr;
         if (!head_data.state_match[CAND_AVAILABLE]) begin
            rslt_in.display_mode = DISP_STANDBY;
         end else if (head_data.pwr == cfg_limited) begin
            rslt_in.display_mode = DISP_LIMITED;
         end else begin
            rslt_in.display_mode = DISP_FULL;
         end
         rslt_in.stamp_year   = ({7'b0, yr_hi} << 6) + ({7'b0, yr_hi} << 5) +
                                ({7'b0, yr_hi} << 2) + {7'b0, yr_lo};
         rslt_in.stamp_month  = mo[3:0];
         rslt_in.stamp_day    = dy[4:0];
         rslt_in.stamp_hour   = hr[4:0];
         rslt_in.stamp_minute = mi[5:0];
         rslt_in.stamp_second = se[5:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (pop) begin
         valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         valid_ff <= 1'b0;
      end
      if (pop) begin
         rslt_ff <= rslt_in;
      end
   end

endmodule

FILE: hdl/command_line_parse_validate.sv
// channel  | direction | handshake             | payload
// req      | in        | req_valid / req_ready | req_rx_byte
// rsp      | out       | rsp_valid / rsp_ready | rsp_error_code .. rsp_stamp_second
// csr      | in        | psel/penable/pwrite   | paddr, pwdata, prdata (64 bit)
//
// One word per cycle in; a CR or LF word that is taken gives a result word that
// passes through the line queue, then the output register, where rsp_valid rises.
// req_ready drops only while the line queue is full (two finished lines
// waiting on a stalled rsp side).
// Reset is synchronous: it clears the line state, the queue pointers, the rsp
// valid flag and the config registers; queue entries, the result register and
// the timestamp bytes hold no reset value.
module command_line_parse_validate import clpv_pkg::*; #(
   parameter int LINE_LIMIT   = 128,
   parameter int ID_MAX_CHARS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [3:0]  rsp_error_code,
   output logic [31:0] rsp_command_id,
   output logic        rsp_target_available,
   output logic [31:0] rsp_power_limit_w,
   output logic [1:0]  rsp_display_mode,
   output logic [13:0] rsp_stamp_year,
   output logic [3:0]  rsp_stamp_month,
   output logic [4:0]  rsp_stamp_day,
   output logic [4:0]  rsp_stamp_hour,
   output logic [5:0]  rsp_stamp_minute,
   output logic [5:0]  rsp_stamp_second,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [5:0]  paddr,
   input  logic [63:0] pwdata,
   output logic [63:0] prdata,
   output logic        pready
);

   // configuration registers
   logic [4:0]  id_len_ff;
   logic [63:0] id_first_ff;
   logic [63:0] id_second_ff;
   logic [31:0] limited_ff;
   logic [31:0] full_ff;
   logic        csr_wr;
   logic [2:0]  csr_idx;

   // front to queue to back
   logic     q_push;
   logic     q_full;
   logic     q_pop;
   logic     q_valid;
   summ_type q_wdata;
   summ_type q_head;
   rslt_type rslt;

   assign pready  = 1'b1;
   assign csr_idx = paddr[5:3];
   assign csr_wr  = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         id_len_ff    <= 5'd0;
         id_first_ff  <= 64'd0;
         id_second_ff <= 64'd0;
         limited_ff   <= 32'd0;
         full_ff      <= 32'd0;
      end else if (csr_wr) begin
         unique case (csr_idx)
            REG_ID_LEN:    id_len_ff    <= pwdata[4:0];
            REG_ID_FIRST:  id_first_ff  <= pwdata;
            REG_ID_SECOND: id_second_ff <= pwdata;
            REG_LIMITED:   limited_ff   <= pwdata[31:0];
            REG_FULL:      full_ff      <= pwdata[31:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         REG_ID_LEN:    prdata = {59'b0, id_len_ff};
         REG_ID_FIRST:  prdata = id_first_ff;
         REG_ID_SECOND: prdata = id_second_ff;
         REG_LIMITED:   prdata = {32'b0, limited_ff};
         REG_FULL:      prdata = {32'b0, full_ff};
         default:       prdata = 64'd0;
      endcase
   end

   // front: per-character field tracking, classifies each line at its end
   clpv_front #(
      .LINE_LIMIT   (LINE_LIMIT),
      .ID_MAX_CHARS (ID_MAX_CHARS)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_rx_byte (req_rx_byte),
      .cfg_id_len  (id_len_ff),
      .cfg_id      ({id_second_ff, id_first_ff}),
      .q_full      (q_full),
      .q_push      (q_push),
      .q_data      (q_wdata)
   );

   clpv_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_data  (q_wdata),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (q_valid),
      .head_data  (q_head)
   );

   // back: timestamp and power checks, result decode, output register
   clpv_back u_back (
      .clock       (clock),
      .reset       (reset),
      .head_valid  (q_valid),
      .head_data   (q_head),
      .pop         (q_pop),
      .cfg_limited (limited_ff),
      .cfg_full    (full_ff),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rslt        (rslt)
   );

   assign rsp_error_code       = rslt.error_code;
   assign rsp_command_id       = rslt.command_id;
   assign rsp_target_available = rslt.target_available;
   assign rsp_power_limit_w    = rslt.power_limit_w;
   assign rsp_display_mode     = rslt.display_mode;
   assign rsp_stamp_year       = rslt.stamp_year;
   assign rsp_stamp_month      = rslt.stamp_month;
   assign rsp_stamp_day        = rslt.stamp_day;
   assign rsp_stamp_hour       = rslt.stamp_hour;
   assign rsp_stamp_minute     = rslt.stamp_minute;
   assign rsp_stamp_second     = rslt.stamp_second;

endmodule

FILE: hdl/clpv_checker.sv
module clpv_checker import clpv_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [3:0]  rsp_error_code,
   input logic [31:0] rsp_command_id,
   input logic        rsp_target_available,
   input logic [31:0] rsp_power_limit_w,
   input logic [1:0]  rsp_display_mode
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_error_code))
      else $error("rsp word dropped or changed under stall");

   a_code_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_error_code <= ERR_STAMP)
      else $error("error code out of range");

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_error_code != ERR_OK |->
         rsp_command_id == 32'd0 && rsp_power_limit_w == 32'd0 &&
         rsp_display_mode == DISP_STANDBY && !rsp_target_available)
      else $error("fields not cleared on error");

   a_ok_cmd: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_error_code == ERR_OK |-> rsp_command_id != 32'd0)
      else $error("accepted line with zero command id");

   a_standby: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_error_code == ERR_OK && !rsp_target_available |->
         rsp_power_limit_w == 32'd0 && rsp_display_mode == DISP_STANDBY)
      else $error("standby with power or display mode");

endmodule

bind command_line_parse_validate clpv_checker u_clpv_checker (
   .clock                (clock),
   .reset                (reset),
   .rsp_valid            (rsp_valid),
   .rsp_ready            (rsp_ready),
   .rsp_error_code       (rsp_error_code),
   .rsp_command_id       (rsp_command_id),
   .rsp_target_available (rsp_target_available),
   .rsp_power_limit_w    (rsp_power_limit_w),
   .rsp_display_mode     (rsp_display_mode)
);
